@@ hw/rtl/rle8_pkg.sv @@
package rle8_pkg;

	// Position arithmetic: the pixel position saturates at 2^PosBits.
	localparam int PosBits = 24;
	localparam int PosW    = PosBits + 1;
	localparam int ByteW   = 8;
	localparam int StartW  = 24;
	localparam int KindW   = 2;
	localparam int CfgW    = 13;
	localparam int CfgIdxW = 1;
	localparam int BoundW  = 2 * CfgW;

	// Widths of the intermediate sums, wide enough never to wrap.
	localparam int SumW   = PosW + 1;
	localparam int CmpW   = (SumW > BoundW) ? SumW : BoundW;
	localparam int ProdW  = ByteW + CfgW;
	localparam int DeltaW = ((PosW > ProdW) ? PosW : ProdW) + 2;

	// Result queue between the parser and the output ports.
	localparam int FifoDepth = 4;
	localparam int FifoPtrW  = $clog2(FifoDepth);
	localparam int FifoCntW  = $clog2(FifoDepth + 1);

	typedef enum logic [KindW-1:0] {
		KindRun      = 2'd0,
		KindDone     = 2'd1,
		KindOverflow = 2'd2
	} kind_t;

	typedef enum logic [CfgIdxW-1:0] {
		CfgWidth  = 1'b0,
		CfgHeight = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic             valid;
		cfg_idx_t         index;
		logic [CfgW-1:0]  data;
	} cfg_wr_t;

	typedef struct packed {
		kind_t              kind;
		logic [StartW-1:0]  start_index;
		logic [ByteW-1:0]   run_length;
		logic [ByteW-1:0]   pixel_value;
	} result_t;

endpackage

@@ hw/rtl/rle8_bitmap_decoder.sv @@
// RLE8 bitmap decoder. Encoded bytes enter through push/full, one per cycle with no
// bubbles while full is low: the parser updates its phase, position and counts in the
// cycle a byte is accepted (one shared add and compare for the bound check, one 8x13
// multiply for the delta row step), and any result is written into a four-entry result
// queue the same cycle, so it shows on the result ports when it is at the queue head. full rises
// only when four results wait unread; otherwise input and output never stall each other.
// The bound width*height is formed when a geometry register is written, so bytes may
// follow a configuration write in the very next cycle. cfg_ready is always high.
module rle8_bitmap_decoder (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  logic [7:0]                     code_byte,
	input  logic                           last_byte,
	output logic                           empty,
	input  logic                           pop,
	output logic [1:0]                     kind,
	output logic [23:0]                    start_index,
	output logic [7:0]                     run_length,
	output logic [7:0]                     pixel_value,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [rle8_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [rle8_pkg::CfgW-1:0]      cfg_data
);
	import rle8_pkg::*;

	cfg_wr_t  cfg;
	result_t  front_res;
	result_t  head;
	logic     front_emit;
	logic     acc;

	// Configuration is always taken at once.
	assign cfg_ready = 1'b1;
	assign cfg.valid = cfg_valid;
	assign cfg.index = cfg_idx_t'(cfg_index);
	assign cfg.data  = cfg_data;

	assign acc = push && !full;

	// Parser front end.
	rle8_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.acc       (acc),
		.code_byte (code_byte),
		.last_byte (last_byte),
		.emit      (front_emit),
		.res       (front_res)
	);

	// Result queue feeding the output side.
	rle8_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (front_emit),
		.wdata  (front_res),
		.full   (full),
		.rd     (pop),
		.empty  (empty),
		.rdata  (head)
	);

	assign kind        = head.kind;
	assign start_index = head.start_index;
	assign run_length  = head.run_length;
	assign pixel_value = head.pixel_value;

endmodule

@@ hw/rtl/rle8_front.sv @@
module rle8_front (
	input  logic              clk,
	input  logic              arst_n,
	input  rle8_pkg::cfg_wr_t cfg,
	input  logic              acc,
	input  logic [7:0]        code_byte,
	input  logic              last_byte,
	output logic              emit,
	output rle8_pkg::result_t res
);
	import rle8_pkg::*;

	typedef enum logic [2:0] {
		PhCount,
		PhValue,
		PhEscape,
		PhDeltaX,
		PhDeltaY,
		PhLiteral,
		PhPad
	} phase_t;

	localparam logic [ByteW-1:0] EscEol   = 8'd0;
	localparam logic [ByteW-1:0] EscEob   = 8'd1;
	localparam logic [ByteW-1:0] EscDelta = 8'd2;
	localparam logic [PosW-1:0]  PosMax   = {1'b1, {PosBits{1'b0}}};

	phase_t              phase_q, phase_n;
	logic [PosW-1:0]     pos_q, pos_n;
	logic [ByteW-1:0]    pend_q, pend_n;
	logic [ByteW-1:0]    lit_rem_q, lit_rem_n;
	logic                lit_odd_q, lit_odd_n;
	logic [ByteW-1:0]    dcol_q, dcol_n;
	logic [CfgW-1:0]     width_q;
	logic [CfgW-1:0]     height_q;
	logic [BoundW-1:0]   bound_q;

	logic [ByteW-1:0]    addend;
	logic [SumW-1:0]     run_sum;
	logic                run_ovf;
	logic [ProdW-1:0]    prod;
	logic [DeltaW-1:0]   delta_sum;
	logic [PosW-1:0]     run_pos;
	logic [PosW-1:0]     delta_pos;
	logic [PosW-1:0]     inc_pos;
	logic                emit_c;
	logic                rst_c;

	// Shared adder: run count in the value phase, literal count at an escape.
	always_comb begin
		addend    = (phase_q == PhValue) ? pend_q : code_byte;
		run_sum   = SumW'(pos_q) + SumW'(addend);
		run_ovf   = CmpW'(run_sum) > CmpW'(bound_q);
		prod      = ProdW'(code_byte) * ProdW'(width_q);
		delta_sum = DeltaW'(pos_q) + DeltaW'(dcol_q) + DeltaW'(prod);
		run_pos   = (run_sum > SumW'(PosMax)) ? PosMax : PosW'(run_sum);
		delta_pos = (delta_sum > DeltaW'(PosMax)) ? PosMax : PosW'(delta_sum);
		inc_pos   = (pos_q == PosMax) ? PosMax : pos_q + 1'b1;
	end

	// Byte parser: next phase, counters and the result for this beat.
	always_comb begin
		phase_n   = phase_q;
		pos_n     = pos_q;
		pend_n    = pend_q;
		lit_rem_n = lit_rem_q;
		lit_odd_n = lit_odd_q;
		dcol_n    = dcol_q;
		emit_c    = 1'b0;
		rst_c     = 1'b0;
		res       = '{kind: KindRun, start_index: '0, run_length: '0, pixel_value: '0};
		unique case (phase_q)
			PhCount: begin
				if (code_byte != EscEol) begin
					pend_n  = code_byte;
					phase_n = PhValue;
				end else begin
					phase_n = PhEscape;
				end
			end
			PhValue: begin
				emit_c = 1'b1;
				if (run_ovf) begin
					res.kind = KindOverflow;
					rst_c    = 1'b1;
				end else begin
					res.start_index = StartW'(pos_q);
					res.run_length  = pend_q;
					res.pixel_value = code_byte;
					pos_n           = run_pos;
					phase_n         = PhCount;
				end
			end
			PhEscape: begin
				if (code_byte == EscEol) begin
					phase_n = PhCount;
				end else if (code_byte == EscEob) begin
					emit_c   = 1'b1;
					res.kind = KindDone;
					rst_c    = 1'b1;
				end else if (code_byte == EscDelta) begin
					phase_n = PhDeltaX;
				end else if (run_ovf) begin
					emit_c   = 1'b1;
					res.kind = KindOverflow;
					rst_c    = 1'b1;
				end else begin
					lit_rem_n = code_byte;
					lit_odd_n = code_byte[0];
					phase_n   = PhLiteral;
				end
			end
			PhDeltaX: begin
				dcol_n  = code_byte;
				phase_n = PhDeltaY;
			end
			PhDeltaY: begin
				pos_n   = delta_pos;
				phase_n = PhCount;
			end
			PhLiteral: begin
				emit_c          = 1'b1;
				res.start_index = StartW'(pos_q);
				res.run_length  = ByteW'(1);
				res.pixel_value = code_byte;
				pos_n           = inc_pos;
				lit_rem_n       = lit_rem_q - 1'b1;
				if (lit_rem_n == '0) begin
					phase_n = lit_odd_q ? PhPad : PhCount;
				end
			end
			PhPad: begin
				phase_n = PhCount;
			end
			default: begin
				rst_c = 1'b1;
			end
		endcase
		// Done, overflow and the final byte all return the parser to its start.
		if (rst_c || last_byte) begin
			phase_n   = PhCount;
			pos_n     = '0;
			pend_n    = '0;
			lit_rem_n = '0;
			lit_odd_n = 1'b0;
			dcol_n    = '0;
		end
	end

	assign emit = acc && emit_c;

	// Parser state, advanced once per accepted beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PhCount;
			pos_q     <= '0;
			pend_q    <= '0;
			lit_rem_q <= '0;
			lit_odd_q <= 1'b0;
			dcol_q    <= '0;
		end else if (acc) begin
			phase_q   <= phase_n;
			pos_q     <= pos_n;
			pend_q    <= pend_n;
			lit_rem_q <= lit_rem_n;
			lit_odd_q <= lit_odd_n;
			dcol_q    <= dcol_n;
		end
	end

	// Geometry registers; the pixel bound is formed as each one is written.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CfgW'(1);
			height_q <= CfgW'(1);
			bound_q  <= BoundW'(1);
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CfgWidth: begin
					width_q <= cfg.data;
					bound_q <= BoundW'(cfg.data) * BoundW'(height_q);
				end
				CfgHeight: begin
					height_q <= cfg.data;
					bound_q  <= BoundW'(width_q) * BoundW'(cfg.data);
				end
				default: begin
					bound_q <= bound_q;
				end
			endcase
		end
	end

	a_restart_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && last_byte) |=> (phase_q == PhCount && pos_q == '0))
		else $error("parser did not restart after the final byte");

	a_pos_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= PosMax)
		else $error("pixel position passed its saturation limit");

	a_status_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && res.kind != KindRun) |-> (res.start_index == '0 && res.run_length == '0))
		else $error("status result carries run fields");

endmodule

@@ hw/rtl/rle8_fifo.sv @@
module rle8_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr,
	input  rle8_pkg::result_t wdata,
	output logic              full,
	input  logic              rd,
	output logic              empty,
	output rle8_pkg::result_t rdata
);
	import rle8_pkg::*;

	result_t               mem_q [FifoDepth];
	logic [FifoPtrW-1:0]   wr_ptr_q;
	logic [FifoPtrW-1:0]   rd_ptr_q;
	logic [FifoCntW-1:0]   cnt_q;
	logic                  wr_en;
	logic                  rd_en;

	assign full  = (cnt_q == FifoCntW'(FifoDepth));
	assign empty = (cnt_q == '0);
	assign wr_en = wr && !full;
	assign rd_en = rd && !empty;
	assign rdata = mem_q[rd_ptr_q];

	// Result storage; entries carry no reset.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= FifoCntW'(FifoDepth))
		else $error("result queue count beyond its depth");

	a_pop_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_en && !wr_en) |=> cnt_q == $past(cnt_q) - 1'b1)
		else $error("result queue count did not fall on a pop");

endmodule

@@ verif/rle8_bitmap_decoder_test.sv @@
`timescale 1ns / 100ps

module rle8_bitmap_decoder_test;
	import rle8_pkg::*;

	localparam int SettleCycles = 8;
	localparam int StuckLimit   = 2000;
	localparam int ShapeCount   = 8;

	// Escape byte and the commands that may follow it.
	localparam int EscapeByte   = 0;
	localparam int EscEndLine   = 0;
	localparam int EscEndBitmap = 1;
	localparam int EscDelta     = 2;

	localparam longint unsigned PosCap = 64'd1 << PosBits;

	typedef enum logic [2:0] {
		PhCount, PhValue, PhEscape, PhDeltaX, PhDeltaY, PhLiteral, PhPad
	} parse_t;

	// One row of the directed plan: a geometry write or one encoded byte.
	typedef struct packed {
		bit               geometry;
		logic [CfgW-1:0]  w;
		logic [CfgW-1:0]  h;
		logic [7:0]       code;
		bit               last;
		bit               typed;
		result_t          want;
	} step_t;

	logic                clk;
	logic                arst_n      = 1'b0;
	logic                push        = 1'b0;
	logic                full;
	logic [7:0]          code_byte   = 8'd0;
	logic                last_byte   = 1'b0;
	logic                empty;
	logic                pop         = 1'b0;
	logic [1:0]          kind;
	logic [23:0]         start_index;
	logic [7:0]          run_length;
	logic [7:0]          pixel_value;
	logic                cfg_valid   = 1'b0;
	logic                cfg_ready;
	logic [CfgIdxW-1:0]  cfg_index   = CfgWidth;
	logic [CfgW-1:0]     cfg_data    = '0;

	// Shadow of the decoder: geometry and parse state.
	logic [CfgW-1:0]  img_w     = 13'd1;
	logic [CfgW-1:0]  img_h     = 13'd1;
	parse_t           phase     = PhCount;
	longint unsigned  pix_pos   = 0;
	logic [7:0]       pend      = 8'd0;
	logic [7:0]       lit_left  = 8'd0;
	bit               lit_odd   = 1'b0;
	logic [7:0]       dcol      = 8'd0;

	result_t  due_descriptors [$];
	step_t    plan [$];
	int       mismatches = 0;
	int       bytes_sent = 0;
	int       pop_wait   = 0;
	int       stuck      = 0;
	bit       moved      = 1'b0;
	bit       calm       = 1'b0;

	rle8_bitmap_decoder dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.code_byte   (code_byte),
		.last_byte   (last_byte),
		.empty       (empty),
		.pop         (pop),
		.kind        (kind),
		.start_index (start_index),
		.run_length  (run_length),
		.pixel_value (pixel_value),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Gap lengths: mostly none or short, now and then a long one.
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic bit rare_last();
		return $urandom_range(0, 199) == 0;
	endfunction

	function automatic longint unsigned clamp_pos(input longint unsigned p);
		return (p > PosCap) ? PosCap : p;
	endfunction

	// Advances the shadow parser by one byte and returns whether it yields a descriptor.
	function automatic bit decode_byte(input logic [7:0] b, input bit lst, output result_t beat);
		longint unsigned bound;
		bit hit;
		bit rst;
		bound = 64'(img_w) * 64'(img_h);
		hit = 1'b0;
		rst = 1'b0;
		beat = '0;
		case (phase)
			PhCount: begin
				if (b != 8'd0) begin
					pend = b;
					phase = PhValue;
				end else begin
					phase = PhEscape;
				end
			end
			PhValue: begin
				hit = 1'b1;
				if (pix_pos + pend > bound) begin
					beat.kind = KindOverflow;
					rst = 1'b1;
				end else begin
					beat.kind = KindRun;
					beat.start_index = 24'(pix_pos);
					beat.run_length = pend;
					beat.pixel_value = b;
					pix_pos = clamp_pos(pix_pos + pend);
					phase = PhCount;
				end
			end
			PhEscape: begin
				if (b == 8'(EscEndLine)) begin
					phase = PhCount;
				end else if (b == 8'(EscEndBitmap)) begin
					hit = 1'b1;
					beat.kind = KindDone;
					rst = 1'b1;
				end else if (b == 8'(EscDelta)) begin
					phase = PhDeltaX;
				end else if (pix_pos + b > bound) begin
					hit = 1'b1;
					beat.kind = KindOverflow;
					rst = 1'b1;
				end else begin
					lit_left = b;
					lit_odd = b[0];
					phase = PhLiteral;
				end
			end
			PhDeltaX: begin
				dcol = b;
				phase = PhDeltaY;
			end
			PhDeltaY: begin
				pix_pos = clamp_pos(pix_pos + dcol + 64'(b) * 64'(img_w));
				phase = PhCount;
			end
			PhLiteral: begin
				hit = 1'b1;
				beat.kind = KindRun;
				beat.start_index = 24'(pix_pos);
				beat.run_length = 8'd1;
				beat.pixel_value = b;
				pix_pos = clamp_pos(pix_pos + 1);
				lit_left = lit_left - 8'd1;
				if (lit_left == 8'd0) phase = lit_odd ? PhPad : PhCount;
			end
			PhPad: begin
				phase = PhCount;
			end
			default: begin
				rst = 1'b1;
			end
		endcase
		// Done, an error or the final byte all bring the parser back to its start.
		if (rst || lst) begin
			phase = PhCount;
			pix_pos = 0;
			pend = 8'd0;
			lit_left = 8'd0;
			lit_odd = 1'b0;
			dcol = 8'd0;
		end
		return hit;
	endfunction

	function automatic step_t raw(input logic [7:0] code, input bit last);
		step_t s;
		s = '0;
		s.code = code;
		s.last = last;
		return s;
	endfunction

	function automatic step_t known(input logic [7:0] code, input bit last, input kind_t k,
			input logic [23:0] start, input logic [7:0] len, input logic [7:0] val);
		step_t s;
		s = raw(code, last);
		s.typed = 1'b1;
		s.want.kind = k;
		s.want.start_index = start;
		s.want.run_length = len;
		s.want.pixel_value = val;
		return s;
	endfunction

	function automatic step_t geom(input logic [CfgW-1:0] w, input logic [CfgW-1:0] h);
		step_t s;
		s = '0;
		s.geometry = 1'b1;
		s.w = w;
		s.h = h;
		return s;
	endfunction

	task automatic flag(input string what);
		mismatches++;
		if (mismatches <= 40) $display("mismatch at %0t: %s", $time, what);
	endtask

	// Offers one byte after an optional gap and records what it should produce.
	task automatic send_byte(input int b, input bit lst, input bit typed = 1'b0,
			input result_t want = '0);
		result_t got;
		bit hit;
		int gap;
		gap = calm ? 0 : idle_len();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		code_byte <= 8'(b);
		last_byte <= lst;
		@(negedge clk);
		while (full) @(negedge clk);
		@(posedge clk);
		hit = decode_byte(8'(b), lst, got);
		if (typed) due_descriptors.push_back(want);
		else if (hit) due_descriptors.push_back(got);
		bytes_sent++;
	endtask

	// Holds the input back until every awaited beat has come, then lets the block settle.
	task automatic settle();
		push <= 1'b0;
		while (due_descriptors.size() != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	// Writes width then height, keeping valid high across both beats.
	task automatic set_geometry(input logic [CfgW-1:0] w, input logic [CfgW-1:0] h);
		cfg_valid <= 1'b1;
		cfg_index <= CfgWidth;
		cfg_data <= w;
		@(negedge clk);
		while (!cfg_ready) @(negedge clk);
		@(posedge clk);
		img_w = w;
		cfg_index <= CfgHeight;
		cfg_data <= h;
		@(negedge clk);
		while (!cfg_ready) @(negedge clk);
		@(posedge clk);
		img_h = h;
		cfg_valid <= 1'b0;
	endtask

	// One command of random content; most are well formed, some are noise or cut short.
	task automatic random_command();
		int pick;
		int n;
		int cut;
		pick = $urandom_range(0, 99);
		if (pick < 38) begin
			n = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 16);
			send_byte(n, rare_last());
			send_byte($urandom_range(0, 255), rare_last());
		end else if (pick < 55) begin
			n = ($urandom_range(0, 5) == 0) ? $urandom_range(3, 255) : $urandom_range(3, 12);
			send_byte(EscapeByte, rare_last());
			send_byte(n, rare_last());
			repeat (n) send_byte($urandom_range(0, 255), rare_last());
			if (n % 2 != 0) send_byte($urandom_range(0, 255), rare_last());
		end else if (pick < 65) begin
			send_byte(EscapeByte, rare_last());
			send_byte(EscDelta, rare_last());
			send_byte($urandom_range(0, 255), rare_last());
			n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 3);
			send_byte(n, rare_last());
		end else if (pick < 70) begin
			send_byte(EscapeByte, rare_last());
			send_byte(EscEndLine, rare_last());
		end else if (pick < 73) begin
			send_byte(EscapeByte, 1'b0);
			send_byte(EscEndBitmap, 1'b0);
		end else if (pick < 76) begin
			// Far jumps drive the position toward saturation before a run; at the largest widths they reach it.
			repeat ($urandom_range(9, 11)) begin
				send_byte(EscapeByte, 1'b0);
				send_byte(EscDelta, 1'b0);
				send_byte(255, 1'b0);
				send_byte(255, 1'b0);
			end
			send_byte($urandom_range(1, 255), 1'b0);
			send_byte($urandom_range(0, 255), 1'b0);
		end else if (pick < 88) begin
			send_byte($urandom_range(0, 255), $urandom_range(0, 3) == 0);
		end else if (pick < 95) begin
			n = $urandom_range(3, 20);
			cut = $urandom_range(2, n);
			send_byte(EscapeByte, 1'b0);
			send_byte(n, 1'b0);
			for (int i = 2; i <= cut; i++) send_byte($urandom_range(0, 255), i == cut);
		end else begin
			send_byte(EscapeByte, 1'b0);
			send_byte(EscDelta, 1'b0);
			send_byte($urandom_range(0, 255), 1'b1);
		end
	endtask

	// The receiver takes beats with random stalls, or none in calm stretches.
	always @(posedge clk) begin
		if (pop_wait > 0) begin
			pop <= 1'b0;
			pop_wait <= pop_wait - 1;
		end else begin
			pop <= 1'b1;
			pop_wait <= calm ? 0 : idle_len();
		end
	end

	// Outputs are stable at the falling edge; each beat taken is checked there.
	always @(negedge clk) begin : check_beat
		result_t want;
		moved = (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready);
		if (arst_n && pop && !empty) begin
			if (due_descriptors.size() == 0) begin
				flag($sformatf("unexpected beat kind %0d start %0d length %0d value %0d",
					kind, start_index, run_length, pixel_value));
			end else begin
				want = due_descriptors.pop_front();
				if (kind !== want.kind)
					flag($sformatf("kind %0d, expected %0d", kind, want.kind));
				if (start_index !== want.start_index)
					flag($sformatf("start_index %0d, expected %0d", start_index,
						want.start_index));
				if (run_length !== want.run_length)
					flag($sformatf("run_length %0d, expected %0d", run_length,
						want.run_length));
				if (pixel_value !== want.pixel_value)
					flag($sformatf("pixel_value %0d, expected %0d", pixel_value,
						want.pixel_value));
			end
		end
	end

	// Watchdog: too long without any beat on any channel ends the run.
	always @(posedge clk) begin
		if (moved) begin
			stuck <= 0;
		end else if (arst_n) begin
			stuck <= stuck + 1;
		end
		if (stuck >= StuckLimit) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		logic [CfgW-1:0] shape_w [ShapeCount];
		logic [CfgW-1:0] shape_h [ShapeCount];
		int goal;

		shape_w = '{13'd16, 13'd8191, 13'd1, 13'd0, 13'd640, 13'd4096, 13'd8191, 13'd1};
		shape_h = '{13'd16, 13'd8191, 13'd1, 13'd300, 13'd480, 13'd4096, 13'd0, 13'd1};
		shape_w[ShapeCount-1] = 13'($urandom_range(1, 8191));
		shape_h[ShapeCount-1] = 13'($urandom_range(1, 64));
		goal = 0;

		plan = '{
			// Reset geometry is a single pixel: one run fits, the next overflows.
			raw(8'h01, 1'b0),
			known(8'hFF, 1'b0, KindRun, 24'd0, 8'd1, 8'hFF),
			raw(8'h01, 1'b0),
			known(8'h00, 1'b0, KindOverflow, 24'd0, 8'd0, 8'd0),
			raw(8'(EscapeByte), 1'b0),
			known(8'(EscEndBitmap), 1'b0, KindDone, 24'd0, 8'd0, 8'd0),
			// Largest geometry: longest run, end of line, literal with pad, delta.
			geom(13'd8191, 13'd8191),
			raw(8'hFF, 1'b0),
			known(8'h5A, 1'b0, KindRun, 24'd0, 8'd255, 8'h5A),
			raw(8'(EscapeByte), 1'b0),
			raw(8'(EscEndLine), 1'b0),
			raw(8'(EscapeByte), 1'b0),
			raw(8'h03, 1'b0),
			raw(8'h00, 1'b0),
			raw(8'hFF, 1'b0),
			raw(8'h80, 1'b0),
			raw(8'h77, 1'b0),
			raw(8'(EscapeByte), 1'b0),
			raw(8'(EscDelta), 1'b0),
			raw(8'hFF, 1'b0),
			raw(8'hFF, 1'b0),
			// A literal cut short by the final byte keeps the writes already made.
			raw(8'(EscapeByte), 1'b0),
			raw(8'h04, 1'b0),
			raw(8'h12, 1'b1),
			// Zero width: every run and every literal overflows.
			geom(13'd0, 13'd8191),
			raw(8'h02, 1'b0),
			known(8'h33, 1'b0, KindOverflow, 24'd0, 8'd0, 8'd0),
			raw(8'(EscapeByte), 1'b0),
			known(8'hFF, 1'b0, KindOverflow, 24'd0, 8'd0, 8'd0)
		};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].geometry) begin
				settle();
				set_geometry(plan[i].w, plan[i].h);
			end else begin
				send_byte(plan[i].code, plan[i].last, plan[i].typed, plan[i].want);
			end
		end

		// Random commands under a series of geometries, two of them without idling.
		for (int p = 0; p < ShapeCount; p++) begin
			settle();
			set_geometry(shape_w[p], shape_h[p]);
			calm <= (p == 2 || p == 5);
			goal = bytes_sent + 115;
			while (bytes_sent < goal) begin
				random_command();
				if ($urandom_range(0, 59) == 0) settle();
			end
		end

		calm <= 1'b0;
		settle();
		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
